### sv/tdg_pkg.sv
// shared types, constants and the arctangent table for the turn-then-drive controller
// no dependencies; every other file of the block imports this package
`default_nettype none

package tdg_pkg;

    // cordic iteration count, capped by the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int IDX_W        = 5;

    // field widths
    localparam int CMD_W    = 2;
    localparam int POS_W    = 32;
    localparam int Q_W      = 16;
    localparam int LIN_W    = 15;
    localparam int ANGCMD_W = 16;
    localparam int RAD_W    = 24;
    localparam int TOL_W    = 14;

    // datapath widths
    localparam int DIF_W     = POS_W + 1;
    localparam int MAG_W     = POS_W;
    localparam int MUL_W     = RAD_W + 1;
    localparam int PRD_W     = 2 * MUL_W;
    localparam int VEC_W     = 34;
    localparam int CRD_W     = 45;
    localparam int ANG_W     = 28;
    localparam int ERR_W     = ANG_W + 1;
    localparam int TOL_SHIFT = 12;

    // cordic normalization limits (bit positions)
    localparam int NORM_BIT  = 40;
    localparam int SMALL_BIT = 32;
    localparam int NORM_STEP = NORM_BIT - SMALL_BIT;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // angle constants, 2^-24 rad
    localparam logic signed [ANG_W-1:0] ANG_PI     = ANG_W'(52707179);
    localparam logic signed [ERR_W-1:0] ERR_PI     = ERR_W'(52707179);
    localparam logic signed [ERR_W-1:0] ERR_NEG_PI = -ERR_W'(52707179);
    localparam logic signed [ERR_W-1:0] ERR_TWO_PI = ERR_W'(105414357);

    // one in Q2.28
    localparam logic signed [PRD_W-1:0] ONE_Q28 = PRD_W'(268435456);

    // input item kinds
    localparam logic [CMD_W-1:0] CMD_POSE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GOAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_RADIUS     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_TOLERANCE = 4'd3;

    // register reset values
    localparam logic [LIN_W-1:0] FORWARD_SPEED_RST     = 15'd819;
    localparam logic [LIN_W-1:0] TURN_SPEED_RST        = 15'd2048;
    localparam logic [RAD_W-1:0] ARRIVE_RADIUS_RST     = 24'd13107;
    localparam logic [TOL_W-1:0] HEADING_TOLERANCE_RST = 14'd410;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic signed [Q_W-1:0]   quat_x;
        logic signed [Q_W-1:0]   quat_y;
        logic signed [Q_W-1:0]   quat_z;
        logic signed [Q_W-1:0]   quat_w;
    } tdg_in_t;

    typedef struct packed {
        logic [LIN_W-1:0]           linear_cmd;
        logic signed [ANGCMD_W-1:0] angular_cmd;
        logic                       reached;
    } tdg_out_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_R,
        ST_DIST,
        ST_HIT,
        ST_Q_WZ,
        ST_Q_XY,
        ST_Q_YY,
        ST_Q_ZZ,
        ST_Q_DEN,
        ST_YAW_GO,
        ST_YAW_WAIT,
        ST_HEAD_GO,
        ST_HEAD_WAIT,
        ST_ERR,
        ST_WRAP0,
        ST_WRAP1,
        ST_OUT
    } tdg_state_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_POSE,
        OP_LOAD_GOAL,
        OP_DIFF,
        OP_ABS,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_R,
        OP_Q_WZ,
        OP_Q_XY,
        OP_Q_YY,
        OP_Q_ZZ,
        OP_Q_DEN,
        OP_YAW_GO,
        OP_HEAD_GO,
        OP_ERR,
        OP_WRAP,
        OP_RESULT_MOVE,
        OP_RESULT_HIT
    } tdg_op_t;

    // cordic unit states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_NORM,
        CS_ITER
    } tdg_cordic_state_t;

    // datapath status back to the controller
    typedef struct packed {
        logic far;
        logic cordic_done;
    } tdg_status_t;

    // atan(2^-i) in 2^-24 rad
    function automatic logic signed [ANG_W-1:0] tdg_atan(input logic [IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            5'd0:    val = ANG_W'(13176795);
            5'd1:    val = ANG_W'(7778716);
            5'd2:    val = ANG_W'(4110060);
            5'd3:    val = ANG_W'(2086331);
            5'd4:    val = ANG_W'(1047214);
            5'd5:    val = ANG_W'(524117);
            5'd6:    val = ANG_W'(262123);
            5'd7:    val = ANG_W'(131069);
            5'd8:    val = ANG_W'(65536);
            5'd9:    val = ANG_W'(32768);
            5'd10:   val = ANG_W'(16384);
            5'd11:   val = ANG_W'(8192);
            5'd12:   val = ANG_W'(4096);
            5'd13:   val = ANG_W'(2048);
            5'd14:   val = ANG_W'(1024);
            5'd15:   val = ANG_W'(512);
            5'd16:   val = ANG_W'(256);
            5'd17:   val = ANG_W'(128);
            5'd18:   val = ANG_W'(64);
            5'd19:   val = ANG_W'(32);
            5'd20:   val = ANG_W'(16);
            5'd21:   val = ANG_W'(8);
            5'd22:   val = ANG_W'(4);
            5'd23:   val = ANG_W'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### sv/tdg_cordic.sv
// iterative cordic atan2 unit: pre-rotate, normalize, then one vectoring step per cycle
// depends on tdg_pkg
`default_nettype none

module tdg_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [tdg_pkg::VEC_W-1:0]   y_in,
    input  logic signed [tdg_pkg::VEC_W-1:0]   x_in,
    output logic                               done,
    output logic signed [tdg_pkg::ANG_W-1:0]   angle
);
    import tdg_pkg::*;

    tdg_cordic_state_t       cstate_reg, cstate_next;
    logic signed [CRD_W-1:0] x_reg, x_next;
    logic signed [CRD_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic                    done_reg, done_next;

    logic signed [CRD_W-1:0] xe, ye, xs, ys;
    logic                    fits_norm, fits_small, y_pos;

    // sign-extended inputs
    assign xe = {{(CRD_W-VEC_W){x_in[VEC_W-1]}}, x_in};
    assign ye = {{(CRD_W-VEC_W){y_in[VEC_W-1]}}, y_in};

    // magnitude checks without an absolute value (x is never negative here)
    assign fits_norm  = ~|x_reg[CRD_W-1:NORM_BIT]
                      & ((~|y_reg[CRD_W-1:NORM_BIT])
                         | ((&y_reg[CRD_W-1:NORM_BIT]) & (|y_reg[NORM_BIT-1:0])));
    assign fits_small = ~|x_reg[CRD_W-1:SMALL_BIT]
                      & ((~|y_reg[CRD_W-1:SMALL_BIT])
                         | ((&y_reg[CRD_W-1:SMALL_BIT]) & (|y_reg[SMALL_BIT-1:0])));

    // shifted terms for the current iteration
    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign y_pos = ~y_reg[CRD_W-1] & (|y_reg);

    // next state and datapath
    always_comb
    begin
        cstate_next = cstate_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        i_next      = i_reg;
        done_next   = 1'b0;
        unique case (cstate_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    if (x_in == '0 && y_in == '0)
                    begin
                        z_next    = '0;
                        done_next = 1'b1;
                    end
                    else if (x_in[VEC_W-1])
                    begin
                        x_next      = -xe;
                        y_next      = -ye;
                        z_next      = y_in[VEC_W-1] ? -ANG_PI : ANG_PI;
                        cstate_next = CS_NORM;
                    end
                    else
                    begin
                        x_next      = xe;
                        y_next      = ye;
                        z_next      = '0;
                        cstate_next = CS_NORM;
                    end
                end
            end
            CS_NORM:
            begin
                if (!fits_norm)
                begin
                    i_next      = '0;
                    cstate_next = CS_ITER;
                end
                else if (fits_small)
                begin
                    x_next = x_reg <<< NORM_STEP;
                    y_next = y_reg <<< NORM_STEP;
                end
                else
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
            end
            CS_ITER:
            begin
                if (y_pos)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tdg_atan(i_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tdg_atan(i_reg);
                end
                if (i_reg == IDX_W'(CORDIC_ITERS - 1))
                begin
                    done_next   = 1'b1;
                    cstate_next = CS_IDLE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            default:
            begin
                cstate_next = CS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg <= CS_IDLE;
            i_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cstate_reg <= cstate_next;
            i_reg      <= i_next;
            done_reg   <= done_next;
        end
    end

    // vector and angle registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

    // after pre-rotation x never goes negative
    a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (cstate_reg != CS_IDLE) |-> !x_reg[CRD_W-1])
        else $error("cordic x component went negative");

    // a new run only starts on an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (cstate_reg == CS_IDLE))
        else $error("cordic started while busy");

endmodule

`default_nettype wire

### sv/tdg_datapath.sv
// datapath: configuration, pose and goal storage, shared multiplier, cordic, result register
// depends on tdg_pkg and tdg_cordic
`default_nettype none

module tdg_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tdg_pkg::tdg_in_t                   in_data,
    input  logic                               cfg_valid,
    input  logic [tdg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  tdg_pkg::tdg_op_t                   op,
    output tdg_pkg::tdg_status_t               status,
    output tdg_pkg::tdg_out_t                  out_data
);
    import tdg_pkg::*;

    // configuration registers
    logic [LIN_W-1:0] forward_speed_reg;
    logic [LIN_W-1:0] turn_speed_reg;
    logic [RAD_W-1:0] arrive_radius_reg;
    logic [TOL_W-1:0] heading_tolerance_reg;

    // stored pose and goal
    logic signed [POS_W-1:0] pose_x_reg, pose_y_reg, goal_x_reg, goal_y_reg;
    logic signed [Q_W-1:0]   quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;

    // working registers
    logic signed [DIF_W-1:0] dx_reg, dy_reg;
    logic [MAG_W-1:0]        adx_reg, ady_reg;
    logic                    big_reg;
    logic signed [PRD_W-1:0] p_reg, acc_reg;
    logic signed [VEC_W-1:0] num_reg, den_reg;
    logic signed [ANG_W-1:0] yaw_reg;
    logic signed [ERR_W-1:0] err_reg;
    tdg_out_t                out_data_reg;

    logic [DIF_W-1:0]        adx_full, ady_full;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] prod;
    logic                    cordic_start, cordic_done;
    logic signed [VEC_W-1:0] cordic_y, cordic_x;
    logic signed [ANG_W-1:0] angle;
    logic signed [ERR_W-1:0] err_wrap, tol_ang;
    logic [ANGCMD_W-1:0]     turn_mag;
    logic                    turning;
    tdg_out_t                move_res, hit_res;

    // configuration writes, bits above a register's width dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_speed_reg     <= FORWARD_SPEED_RST;
            turn_speed_reg        <= TURN_SPEED_RST;
            arrive_radius_reg     <= ARRIVE_RADIUS_RST;
            heading_tolerance_reg <= HEADING_TOLERANCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FORWARD_SPEED:     forward_speed_reg     <= cfg_data[LIN_W-1:0];
                REG_TURN_SPEED:        turn_speed_reg        <= cfg_data[LIN_W-1:0];
                REG_ARRIVE_RADIUS:     arrive_radius_reg     <= cfg_data[RAD_W-1:0];
                REG_HEADING_TOLERANCE: heading_tolerance_reg <= cfg_data[TOL_W-1:0];
                default:               ;
            endcase
        end
    end

    // magnitudes of the offset to the goal
    assign adx_full = dx_reg[DIF_W-1] ? DIF_W'(-dx_reg) : DIF_W'(dx_reg);
    assign ady_full = dy_reg[DIF_W-1] ? DIF_W'(-dy_reg) : DIF_W'(dy_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            OP_SQ_X:
            begin
                mul_a = $signed({1'b0, adx_reg[RAD_W-1:0]});
                mul_b = $signed({1'b0, adx_reg[RAD_W-1:0]});
            end
            OP_SQ_Y:
            begin
                mul_a = $signed({1'b0, ady_reg[RAD_W-1:0]});
                mul_b = $signed({1'b0, ady_reg[RAD_W-1:0]});
            end
            OP_SQ_R:
            begin
                mul_a = $signed({1'b0, arrive_radius_reg});
                mul_b = $signed({1'b0, arrive_radius_reg});
            end
            OP_Q_WZ:
            begin
                mul_a = {{(MUL_W-Q_W){quat_w_reg[Q_W-1]}}, quat_w_reg};
                mul_b = {{(MUL_W-Q_W){quat_z_reg[Q_W-1]}}, quat_z_reg};
            end
            OP_Q_XY:
            begin
                mul_a = {{(MUL_W-Q_W){quat_x_reg[Q_W-1]}}, quat_x_reg};
                mul_b = {{(MUL_W-Q_W){quat_y_reg[Q_W-1]}}, quat_y_reg};
            end
            OP_Q_YY:
            begin
                mul_a = {{(MUL_W-Q_W){quat_y_reg[Q_W-1]}}, quat_y_reg};
                mul_b = {{(MUL_W-Q_W){quat_y_reg[Q_W-1]}}, quat_y_reg};
            end
            OP_Q_ZZ:
            begin
                mul_a = {{(MUL_W-Q_W){quat_z_reg[Q_W-1]}}, quat_z_reg};
                mul_b = {{(MUL_W-Q_W){quat_z_reg[Q_W-1]}}, quat_z_reg};
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // cordic operands: yaw from the quaternion, then heading from the offset
    assign cordic_start = (op == OP_YAW_GO) || (op == OP_HEAD_GO);
    assign cordic_y = (op == OP_HEAD_GO) ? {{(VEC_W-DIF_W){dy_reg[DIF_W-1]}}, dy_reg} : num_reg;
    assign cordic_x = (op == OP_HEAD_GO) ? {{(VEC_W-DIF_W){dx_reg[DIF_W-1]}}, dx_reg} : den_reg;

    tdg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .y_in  (cordic_y),
        .x_in  (cordic_x),
        .done  (cordic_done),
        .angle (angle)
    );

    // one wrap step into [-pi, pi)
    always_comb
    begin
        priority if (err_reg >= ERR_PI)
            err_wrap = err_reg - ERR_TWO_PI;
        else if (err_reg < ERR_NEG_PI)
            err_wrap = err_reg + ERR_TWO_PI;
        else
            err_wrap = err_reg;
    end

    // turn or drive decision
    assign tol_ang  = $signed({{(ERR_W-TOL_W-TOL_SHIFT){1'b0}}, heading_tolerance_reg,
                               {TOL_SHIFT{1'b0}}});
    assign turning  = (err_reg > tol_ang) || (err_reg < -tol_ang);
    assign turn_mag = {1'b0, turn_speed_reg};

    always_comb
    begin
        move_res.reached = 1'b0;
        if (turning)
        begin
            move_res.linear_cmd  = '0;
            move_res.angular_cmd = (err_reg > 0) ? $signed(turn_mag) : $signed(-turn_mag);
        end
        else
        begin
            move_res.linear_cmd  = forward_speed_reg;
            move_res.angular_cmd = '0;
        end
    end

    assign hit_res.linear_cmd  = '0;
    assign hit_res.angular_cmd = '0;
    assign hit_res.reached     = 1'b1;

    // working registers, one operation per cycle
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD_POSE:
            begin
                pose_x_reg <= in_data.x_pos;
                pose_y_reg <= in_data.y_pos;
                quat_x_reg <= in_data.quat_x;
                quat_y_reg <= in_data.quat_y;
                quat_z_reg <= in_data.quat_z;
                quat_w_reg <= in_data.quat_w;
            end
            OP_LOAD_GOAL:
            begin
                goal_x_reg <= in_data.x_pos;
                goal_y_reg <= in_data.y_pos;
            end
            OP_DIFF:
            begin
                dx_reg <= $signed({goal_x_reg[POS_W-1], goal_x_reg})
                        - $signed({pose_x_reg[POS_W-1], pose_x_reg});
                dy_reg <= $signed({goal_y_reg[POS_W-1], goal_y_reg})
                        - $signed({pose_y_reg[POS_W-1], pose_y_reg});
            end
            OP_ABS:
            begin
                adx_reg <= adx_full[MAG_W-1:0];
                ady_reg <= ady_full[MAG_W-1:0];
                big_reg <= (|adx_full[DIF_W-1:RAD_W]) || (|ady_full[DIF_W-1:RAD_W]);
            end
            OP_SQ_X:
            begin
                p_reg <= prod;
            end
            OP_SQ_Y:
            begin
                acc_reg <= p_reg;
                p_reg   <= prod;
            end
            OP_SQ_R:
            begin
                acc_reg <= acc_reg + p_reg;
                p_reg   <= prod;
            end
            OP_Q_WZ:
            begin
                p_reg <= prod;
            end
            OP_Q_XY:
            begin
                acc_reg <= p_reg <<< 1;
                p_reg   <= prod;
            end
            OP_Q_YY:
            begin
                num_reg <= VEC_W'(acc_reg + (p_reg <<< 1));
                p_reg   <= prod;
            end
            OP_Q_ZZ:
            begin
                acc_reg <= ONE_Q28 - (p_reg <<< 1);
                p_reg   <= prod;
            end
            OP_Q_DEN:
            begin
                den_reg <= VEC_W'(acc_reg - (p_reg <<< 1));
            end
            OP_HEAD_GO:
            begin
                yaw_reg <= angle;
            end
            OP_ERR:
            begin
                err_reg <= $signed({angle[ANG_W-1], angle}) - $signed({yaw_reg[ANG_W-1], yaw_reg});
            end
            OP_WRAP:
            begin
                err_reg <= err_wrap;
            end
            OP_RESULT_MOVE:
            begin
                out_data_reg <= move_res;
            end
            OP_RESULT_HIT:
            begin
                out_data_reg <= hit_res;
            end
            default: ;
        endcase
    end

    // status back to the controller
    assign status.far         = big_reg || (acc_reg > p_reg);
    assign status.cordic_done = cordic_done;
    assign out_data           = out_data_reg;

endmodule

`default_nettype wire

### sv/tdg_ctrl.sv
// controller: input and output handshakes, valid flags and the per-tick operation sequence
// depends on tdg_pkg
`default_nettype none

module tdg_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [tdg_pkg::CMD_W-1:0]      in_cmd,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  tdg_pkg::tdg_status_t           status,
    output tdg_pkg::tdg_op_t               op
);
    import tdg_pkg::*;

    tdg_state_t state_reg, state_next;
    logic       pose_valid_reg, pose_valid_next;
    logic       goal_valid_reg, goal_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // output register can take a new result
    assign out_free = !out_valid_reg || out_ready;

    // next state and operation
    always_comb
    begin
        state_next      = state_reg;
        pose_valid_next = pose_valid_reg;
        goal_valid_next = goal_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        op              = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_POSE:
                        begin
                            op              = OP_LOAD_POSE;
                            pose_valid_next = 1'b1;
                        end
                        CMD_GOAL:
                        begin
                            op              = OP_LOAD_GOAL;
                            goal_valid_next = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            if (pose_valid_reg && goal_valid_reg)
                                state_next = ST_DIFF;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIFF:
            begin
                op         = OP_DIFF;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                op         = OP_ABS;
                state_next = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                op         = OP_SQ_X;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                op         = OP_SQ_Y;
                state_next = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                op         = OP_SQ_R;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                state_next = status.far ? ST_Q_WZ : ST_HIT;
            end
            ST_HIT:
            begin
                if (out_free)
                begin
                    op              = OP_RESULT_HIT;
                    goal_valid_next = 1'b0;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_Q_WZ:
            begin
                op         = OP_Q_WZ;
                state_next = ST_Q_XY;
            end
            ST_Q_XY:
            begin
                op         = OP_Q_XY;
                state_next = ST_Q_YY;
            end
            ST_Q_YY:
            begin
                op         = OP_Q_YY;
                state_next = ST_Q_ZZ;
            end
            ST_Q_ZZ:
            begin
                op         = OP_Q_ZZ;
                state_next = ST_Q_DEN;
            end
            ST_Q_DEN:
            begin
                op         = OP_Q_DEN;
                state_next = ST_YAW_GO;
            end
            ST_YAW_GO:
            begin
                op         = OP_YAW_GO;
                state_next = ST_YAW_WAIT;
            end
            ST_YAW_WAIT:
            begin
                if (status.cordic_done)
                    state_next = ST_HEAD_GO;
            end
            ST_HEAD_GO:
            begin
                op         = OP_HEAD_GO;
                state_next = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT:
            begin
                if (status.cordic_done)
                    state_next = ST_ERR;
            end
            ST_ERR:
            begin
                op         = OP_ERR;
                state_next = ST_WRAP0;
            end
            ST_WRAP0:
            begin
                op         = OP_WRAP;
                state_next = ST_WRAP1;
            end
            ST_WRAP1:
            begin
                op         = OP_WRAP;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    op             = OP_RESULT_MOVE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pose_valid_reg <= 1'b0;
            goal_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pose_valid_reg <= pose_valid_next;
            goal_valid_reg <= goal_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // a result never overwrites one still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_RESULT_HIT || op == OP_RESULT_MOVE) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // the step sequence only runs with a stored pose and goal
    a_tick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |-> (pose_valid_reg && goal_valid_reg))
        else $error("tick processed without pose and goal");

    // reaching the goal forgets it and presents a result
    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_RESULT_HIT) |=> (!goal_valid_reg && out_valid_reg))
        else $error("goal not cleared on arrival");

endmodule

`default_nettype wire

### sv/turn_then_drive_goal_controller.sv
// top level of the turn-then-drive goal controller: controller plus datapath
// depends on tdg_pkg, tdg_ctrl, tdg_datapath (and tdg_cordic below it)
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid, in_ready, in_data (tdg_in_t)    | to block
//   out      | out_valid, out_ready, out_data (tdg_out_t)| from block
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | to block
//
// pose and goal updates are loaded straight from idle; a tick without both stored is dropped.
// a tick inside the arrive radius ends after the distance check; any other tick goes on to
// the quaternion steps and two 16-iteration cordic runs, each after its normalize steps, then
// the error and wrap steps; a zero yaw vector skips its run.
// reset brings back the register defaults and clears the pose and goal valid flags.
// a finished result sits in the output register while the next transfer is taken;
// a new result waits only while that register is still full.
`default_nettype none

module turn_then_drive_goal_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tdg_pkg::tdg_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tdg_pkg::tdg_out_t              out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tdg_pkg::*;

    tdg_op_t     op;
    tdg_status_t status;

    // register writes are always taken and land in the next cycle
    assign cfg_ready = 1'b1;

    tdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    tdg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### bench/tb_turn_then_drive_goal_controller.sv
// self-checking bench for the turn-then-drive goal controller: directed and random
// pose, goal and tick streams checked against an in-bench fixed-point predictor
// depends on tdg_pkg and turn_then_drive_goal_controller
module tb_turn_then_drive_goal_controller;
    import tdg_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 11;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int PHASES           = 6;
    localparam int SETTLE_CYCLES    = 100;
    localparam int HOLD_CYCLES      = 400;
    localparam int HOLD_AFTER       = 350;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SHOWN_MAX        = 10;

    localparam logic [CMD_W-1:0]     CMD_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    // fixed-point angle and scale constants, angles in 2^-24 rad
    localparam longint HALF_TURN  = 64'sd52707179;
    localparam longint FULL_TURN  = 64'sd105414357;
    localparam longint UNIT_Q28   = 64'sd268435456;
    localparam longint NORM_FLOOR = 64'sd1099511627776;
    localparam real    PI_R       = 3.141592653589793;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    tdg_in_t  in_data   = '0;
    logic     out_ready = 1'b0;
    logic     cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic     in_ready;
    logic     out_valid;
    logic     cfg_ready;
    tdg_out_t out_data;

    turn_then_drive_goal_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // predictor copy of the stored pose, goal and registers
    logic signed [POS_W-1:0] pose_x_s = '0;
    logic signed [POS_W-1:0] pose_y_s = '0;
    logic signed [POS_W-1:0] goal_x_s = '0;
    logic signed [POS_W-1:0] goal_y_s = '0;
    logic signed [Q_W-1:0]   pose_q [4];
    logic pose_known = 1'b0;
    logic goal_known = 1'b0;
    logic [LIN_W-1:0] fwd_speed_r  = FORWARD_SPEED_RST;
    logic [LIN_W-1:0] turn_speed_r = TURN_SPEED_RST;
    logic [RAD_W-1:0] radius_r     = ARRIVE_RADIUS_RST;
    logic [TOL_W-1:0] tol_r        = HEADING_TOLERANCE_RST;

    tdg_in_t  stim_items [$];
    tdg_out_t expected_cmds [$];
    tdg_out_t want;

    int pushed_count   = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int fault_count    = 0;
    int reached_count  = 0;
    int turn_count     = 0;
    int drive_count    = 0;
    int dropped_ticks  = 0;
    int ignored_items  = 0;
    int burst_left     = 8;
    int gap_left       = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int ready_cycle    = 0;
    int cycle_count    = 0;

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // atan(2^-i) in 2^-24 rad
    function automatic longint atan_step(input int i);
        longint a;
        case (i)
            0:  a = 13176795;
            1:  a = 7778716;
            2:  a = 4110060;
            3:  a = 2086331;
            4:  a = 1047214;
            5:  a = 524117;
            6:  a = 262123;
            7:  a = 131069;
            default: a = longint'(65536) >>> (i - 8);
        endcase
        return a;
    endfunction

    // vectoring cordic atan2 with normalization and pre-rotation for negative x
    function automatic longint fx_atan2(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint z;
        longint m;
        longint t;
        int i;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        m = (mag64(x) > mag64(y)) ? mag64(x) : mag64(y);
        while (m < NORM_FLOOR)
        begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (i = 0; i < CORDIC_ITERS; i++)
        begin
            if (y > 0)
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_step(i);
            end
            else
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_step(i);
            end
            x = t;
        end
        return z;
    endfunction

    // update the stored pose or goal, or run one control step and queue its command
    task automatic apply_item(input tdg_in_t item);
        longint dx;
        longint dy;
        longint adx;
        longint ady;
        longint num;
        longint den;
        longint yaw;
        longint head;
        longint err;
        longint ang;
        bit far;
        tdg_out_t res;
        case (item.cmd)
            CMD_POSE:
            begin
                pose_x_s   = item.x_pos;
                pose_y_s   = item.y_pos;
                pose_q[0]  = item.quat_x;
                pose_q[1]  = item.quat_y;
                pose_q[2]  = item.quat_z;
                pose_q[3]  = item.quat_w;
                pose_known = 1'b1;
            end
            CMD_GOAL:
            begin
                goal_x_s   = item.x_pos;
                goal_y_s   = item.y_pos;
                goal_known = 1'b1;
            end
            CMD_TICK:
            begin
                if (!pose_known || !goal_known)
                    dropped_ticks++;
                else
                begin
                    res = '0;
                    dx  = longint'(goal_x_s) - longint'(pose_x_s);
                    dy  = longint'(goal_y_s) - longint'(pose_y_s);
                    adx = mag64(dx);
                    ady = mag64(dy);
                    if (adx > 64'sd16777215 || ady > 64'sd16777215)
                        far = 1'b1;
                    else
                        far = (adx * adx + ady * ady) > (longint'(radius_r) * longint'(radius_r));
                    if (!far)
                    begin
                        goal_known  = 1'b0;
                        res.reached = 1'b1;
                        reached_count++;
                    end
                    else
                    begin
                        num = 2 * (longint'(pose_q[3]) * longint'(pose_q[2])
                                   + longint'(pose_q[0]) * longint'(pose_q[1]));
                        den = UNIT_Q28 - 2 * (longint'(pose_q[1]) * longint'(pose_q[1])
                                              + longint'(pose_q[2]) * longint'(pose_q[2]));
                        yaw  = fx_atan2(num, den);
                        head = fx_atan2(dy, dx);
                        err  = head - yaw;
                        // wrap into [-pi, pi)
                        repeat (2)
                        begin
                            if (err >= HALF_TURN)
                                err = err - FULL_TURN;
                            if (err < -HALF_TURN)
                                err = err + FULL_TURN;
                        end
                        if (mag64(err) > (longint'(tol_r) <<< TOL_SHIFT))
                        begin
                            if (err > 0)
                                ang = longint'(turn_speed_r);
                            else
                                ang = -longint'(turn_speed_r);
                            res.angular_cmd = ang[ANGCMD_W-1:0];
                            turn_count++;
                        end
                        else
                        begin
                            res.linear_cmd = fwd_speed_r;
                            drive_count++;
                        end
                    end
                    expected_cmds.push_back(res);
                end
            end
            default:
                ignored_items++;
        endcase
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_MAX)
            $display("tb: mismatch: %s", msg);
    endtask

    task automatic push_item(input logic [CMD_W-1:0] cmd, input longint x, input longint y,
                             input int qx, input int qy, input int qz, input int qw);
        tdg_in_t it;
        it.cmd    = cmd;
        it.x_pos  = x[POS_W-1:0];
        it.y_pos  = y[POS_W-1:0];
        it.quat_x = qx[Q_W-1:0];
        it.quat_y = qy[Q_W-1:0];
        it.quat_z = qz[Q_W-1:0];
        it.quat_w = qw[Q_W-1:0];
        stim_items.push_back(it);
        pushed_count++;
    endtask

    function automatic int rand_q();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic real rand_unit();
        return $itor($urandom_range(0, 1000000)) / 1.0e6;
    endfunction

    // register write on the config channel; called at a rising edge
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FORWARD_SPEED:     fwd_speed_r  = value[LIN_W-1:0];
            REG_TURN_SPEED:        turn_speed_r = value[LIN_W-1:0];
            REG_ARRIVE_RADIUS:     radius_r     = value[RAD_W-1:0];
            REG_HEADING_TOLERANCE: tol_r        = value[TOL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // all items taken, all commands back, then a settle period
    task automatic wait_idle();
        while (accepted_count != pushed_count)
            @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly pose, goal and tick sequences shaped to reach, turn or drive; some noise
    task automatic queue_random_items(input int count);
        int made;
        int kind;
        int ticks;
        int k;
        int qx;
        int qy;
        int qz;
        int qw;
        real yaw_r;
        real dir_r;
        real dist_r;
        longint px;
        longint py;
        longint gx;
        longint gy;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                yaw_r = (2.0 * rand_unit() - 1.0) * PI_R;
                px = longint'(int'($urandom) >>> 2);
                py = longint'(int'($urandom) >>> 2);
                if ($urandom_range(0, 4) == 0)
                begin
                    qx = rand_q();
                    qy = rand_q();
                    qz = rand_q();
                    qw = rand_q();
                end
                else
                begin
                    qx = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 400)) - 200 : 0;
                    qy = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 400)) - 200 : 0;
                    qz = $rtoi(16384.0 * $sin(yaw_r / 2.0));
                    qw = $rtoi(16384.0 * $cos(yaw_r / 2.0));
                end
                // a broken sequence now and then keeps the old pose
                if ($urandom_range(0, 7) != 0)
                begin
                    push_item(CMD_POSE, px, py, qx, qy, qz, qw);
                    made++;
                end
                case ($urandom_range(0, 3))
                    0:
                    begin
                        dist_r = $itor(radius_r) * 1.25 * rand_unit();
                        dir_r  = 2.0 * PI_R * rand_unit();
                    end
                    1:
                    begin
                        dist_r = $pow(2.0, 12.0 + 18.0 * rand_unit());
                        dir_r  = yaw_r + (2.0 * rand_unit() - 1.0) * 1.5
                                 * ($itor(tol_r) / 4096.0 + 0.002);
                    end
                    2:
                    begin
                        dist_r = $pow(2.0, 4.0 + 26.0 * rand_unit());
                        dir_r  = (2.0 * rand_unit() - 1.0) * PI_R;
                    end
                    default:
                    begin
                        dist_r = 0.0;
                        dir_r  = 0.0;
                    end
                endcase
                gx = px + longint'($rtoi(dist_r * $cos(dir_r)));
                gy = py + longint'($rtoi(dist_r * $sin(dir_r)));
                push_item(CMD_GOAL, gx, gy, rand_q(), rand_q(), rand_q(), rand_q());
                made++;
                ticks = $urandom_range(1, 3);
                for (k = 0; k < ticks; k++)
                begin
                    if (k > 0 && $urandom_range(0, 3) == 0)
                    begin
                        push_item(CMD_POSE, (px + gx) / 2, (py + gy) / 2, qx, qy, qz, qw);
                        made++;
                    end
                    push_item(CMD_TICK, longint'(int'($urandom)), longint'(int'($urandom)),
                              rand_q(), rand_q(), rand_q(), rand_q());
                    made++;
                end
            end
            else
            begin
                kind = $urandom_range(0, 3);
                push_item(kind[CMD_W-1:0], longint'(int'($urandom)), longint'(int'($urandom)),
                          rand_q(), rand_q(), rand_q(), rand_q());
                if (kind[CMD_W-1:0] != CMD_SPARE)
                    made++;
            end
        end
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_item(in_data);
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_items.size() > 0)
                begin
                    in_data  <= stim_items.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold-off to back up the block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_cycle++;
            if (!hold_done && accepted_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (ready_cycle[7:6])
                    2'd0:    out_ready <= 1'b1;
                    2'd1:    out_ready <= ready_cycle[0];
                    2'd2:    out_ready <= ($urandom_range(0, 1) == 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result check against the oldest predicted command
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_cmds.size() == 0)
                report_fault($sformatf("unexpected result lin=%0d ang=%0d reached=%0b",
                                       out_data.linear_cmd, out_data.angular_cmd,
                                       out_data.reached));
            else
            begin
                want = expected_cmds.pop_front();
                if (out_data.linear_cmd !== want.linear_cmd
                    || out_data.angular_cmd !== want.angular_cmd
                    || out_data.reached !== want.reached)
                    report_fault($sformatf(
                        "expected lin=%0d ang=%0d reached=%0b, got lin=%0d ang=%0d reached=%0b",
                        want.linear_cmd, want.angular_cmd, want.reached,
                        out_data.linear_cmd, out_data.angular_cmd, out_data.reached));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // reset, register settings and stimulus phases
    initial
    begin
        int p;
        for (p = 0; p < 4; p++)
            pose_q[p] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unused index, and data bits above the widths of the speed and tolerance registers
        write_register(REG_UNUSED, 24'hABCDEF);
        write_register(REG_FORWARD_SPEED, {9'h1AB, FORWARD_SPEED_RST});
        write_register(REG_TURN_SPEED, {9'h155, TURN_SPEED_RST});
        write_register(REG_HEADING_TOLERANCE, {10'h3FF, HEADING_TOLERANCE_RST});

        // directed: nothing stored, spare command, heading exactly behind,
        // dead ahead, arrival and cleared goal, degenerate yaw vector, extremes
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_SPARE, -1, -1, 16384, -16384, 16384, -16384);
        push_item(CMD_POSE, 0, 0, 0, 0, 0, 16384);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_GOAL, -64'sd268435456, 0, -16384, 16384, -16384, 16384);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_GOAL, 64'sd268435456, 0, 16384, -16384, 16384, -16384);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_GOAL, 100, -100, 0, 0, 0, 0);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_POSE, -64'sd2147483648, 64'sd2147483647, 5000, 8192, 8192, -5000);
        push_item(CMD_GOAL, 64'sd2147483647, -64'sd2147483648, 0, 0, 0, 0);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_POSE, 0, 0, -16384, -16384, -16384, -16384);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        // yaw numerator and denominator both zero
        push_item(CMD_POSE, 0, 0, 0, 8192, 8192, 0);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_POSE, 12345, -777, 16384, 16384, 16384, 16384);
        push_item(CMD_GOAL, 12345 + 64'sd16777215, -777, 0, 0, 0, 0);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_GOAL, 12345, -777 + 64'sd16777216, 0, 0, 0, 0);
        push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // random phases over several register settings, extremes included
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: ;
                1:
                begin
                    write_register(REG_FORWARD_SPEED, 24'd32767);
                    write_register(REG_TURN_SPEED, 24'd32767);
                    write_register(REG_ARRIVE_RADIUS, 24'd16777215);
                    write_register(REG_HEADING_TOLERANCE, 24'd12868);
                end
                2:
                begin
                    write_register(REG_FORWARD_SPEED, 24'd0);
                    write_register(REG_TURN_SPEED, 24'd0);
                    write_register(REG_ARRIVE_RADIUS, 24'd0);
                    write_register(REG_HEADING_TOLERANCE, 24'd0);
                end
                5:
                begin
                    write_register(REG_FORWARD_SPEED, 24'd1);
                    write_register(REG_TURN_SPEED, 24'd1);
                    write_register(REG_ARRIVE_RADIUS, 24'd131072);
                    write_register(REG_HEADING_TOLERANCE, 24'd1);
                end
                default:
                begin
                    write_register(REG_FORWARD_SPEED, 24'($urandom_range(0, 32767)));
                    write_register(REG_TURN_SPEED, 24'($urandom_range(0, 32767)));
                    write_register(REG_ARRIVE_RADIUS, 24'($urandom_range(0, 1048576)));
                    write_register(REG_HEADING_TOLERANCE, 24'($urandom_range(0, 12868)));
                end
            endcase
            queue_random_items(RANDOM_PER_PHASE);
            wait_idle();
        end

        if (expected_cmds.size() != 0)
            report_fault($sformatf("%0d commands never came out", expected_cmds.size()));
        $display("tb: %0d inputs over %0d register settings, %0d commands checked",
                 accepted_count, PHASES + 1, result_count);
        $display("tb: %0d arrivals, %0d turns, %0d drives, %0d dropped ticks, %0d ignored",
                 reached_count, turn_count, drive_count, dropped_ticks, ignored_items);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
